// ----- hw/rtl/radix2_complex_fft_macros.svh -----
// Assertion macros used by the FFT top-level RTL file.
`ifndef RADIX2_COMPLEX_FFT_MACROS_SVH
`define RADIX2_COMPLEX_FFT_MACROS_SVH
`ifndef SYNTHESIS
`define RFFT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("rfft check failed");
`define RFFT_ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error("rfft check failed");
`else
`define RFFT_ASSERT(lbl, clk, rst_n, prop)
`define RFFT_ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

// ----- hw/rtl/rfft_pkg.sv -----
// Shared constants, types and twiddle tables of the radix-2 FFT.
`default_nettype none
package rfft_pkg;

  localparam int MaxLog2    = 10;
  localparam int MaxPoints  = 1 << MaxLog2;
  localparam int RomSize    = MaxPoints / 2;
  localparam int RomIdxW    = MaxLog2 - 1;
  localparam int SampleBits = 16;
  localparam int DataBits   = SampleBits + MaxLog2;
  localparam int TwBits     = 16;
  localparam int TwFrac     = TwBits - 1;
  localparam int CountW     = MaxLog2 + 1;
  localparam int CfgLogW    = 4;
  localparam int StageW     = 4;

  localparam real Pi = 3.14159265358979323846;

  // operation codes
  localparam logic OpLoad = 1'b0;
  localparam logic OpRead = 1'b1;

  // configuration register indexes
  localparam logic CfgPointsLog2 = 1'b0;
  localparam logic CfgNegExp     = 1'b1;

  typedef struct packed {
    logic signed [DataBits-1:0] re;
    logic signed [DataBits-1:0] im;
  } cword_t;

  typedef struct packed {
    logic mul_en;  // register the four products
    logic t_en;    // register the rounded twiddled value
  } bfly_ctrl_t;

  typedef logic signed [TwBits-1:0] tw_rom_t [RomSize];

  // round half away from zero to TwFrac fraction bits, +1.0 saturated
  function automatic logic signed [TwBits-1:0] tw_round(input real v);
    real mag;
    int  r;
    mag = (v < 0.0) ? -v : v;
    r   = $rtoi(mag * (2.0 ** TwFrac) + 0.5);
    if (r > (1 << TwFrac) - 1) r = (1 << TwFrac) - 1;
    if (v < 0.0) r = -r;
    return TwBits'(r);
  endfunction

  function automatic tw_rom_t build_tw(input bit sine);
    tw_rom_t rom;
    real     a;
    for (int k = 0; k < RomSize; k++) begin
      a      = 2.0 * Pi * k / MaxPoints;
      rom[k] = sine ? tw_round($sin(a)) : tw_round($cos(a));
    end
    return rom;
  endfunction

  localparam tw_rom_t CosRom = build_tw(1'b0);
  localparam tw_rom_t SinRom = build_tw(1'b1);

endpackage
`default_nettype wire

// ----- hw/rtl/rfft_ram.sv -----
// Generic one-write one-read synchronous RAM with registered read data.
`default_nettype none
module rfft_ram #(
  parameter int AddrW = 10,
  parameter int Width = 52
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [1 << AddrW];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- hw/rtl/rfft_bfly.sv -----
// Butterfly datapath: complex multiply, rounding and sum/difference.
`default_nettype none
module rfft_bfly (
  input  logic                               clk_i,
  input  rfft_pkg::bfly_ctrl_t               ctrl_i,
  input  rfft_pkg::cword_t                   xj_i,
  input  rfft_pkg::cword_t                   xi_i,
  input  logic signed [rfft_pkg::TwBits:0]   w_re_i,
  input  logic signed [rfft_pkg::TwBits:0]   w_im_i,
  output rfft_pkg::cword_t                   yi_o,
  output rfft_pkg::cword_t                   yj_o
);

  localparam int ProdW = rfft_pkg::DataBits + rfft_pkg::TwBits + 1;
  localparam int SumW  = ProdW + 1;
  localparam logic signed [SumW-1:0] Half = SumW'(1) <<< (rfft_pkg::TwFrac - 1);

  logic signed [ProdW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [SumW-1:0]  t_re_d, t_im_d;
  logic signed [rfft_pkg::DataBits-1:0] t_re_q, t_im_q;

  // products of twiddle and lower leg
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      p_rr_q <= w_re_i * xj_i.re;
      p_ii_q <= w_im_i * xj_i.im;
      p_ri_q <= w_re_i * xj_i.im;
      p_ir_q <= w_im_i * xj_i.re;
    end
  end

  // round half up, drop fraction bits, wrap to data width
  assign t_re_d = SumW'(p_rr_q) - SumW'(p_ii_q) + Half;
  assign t_im_d = SumW'(p_ri_q) + SumW'(p_ir_q) + Half;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.t_en) begin
      t_re_q <= t_re_d[rfft_pkg::TwFrac +: rfft_pkg::DataBits];
      t_im_q <= t_im_d[rfft_pkg::TwFrac +: rfft_pkg::DataBits];
    end
  end

  assign yi_o.re = xi_i.re + t_re_q;
  assign yi_o.im = xi_i.im + t_im_q;
  assign yj_o.re = xi_i.re - t_re_q;
  assign yj_o.im = xi_i.im - t_im_q;

endmodule
`default_nettype wire

// ----- hw/rtl/radix2_complex_fft.sv -----
// In-place radix-2 DIT FFT: frame RAM, bit-reverse pass and butterfly sequencer.
// A load writes the frame RAM directly. A read of a finished frame passes the RAM
// read register and then the output register, and stalls input until its bin is
// registered; a read before that loads an invalid result into the output register.
// The last load of a frame of N = 2^L starts the transform: a bit-reverse pass, then
// (N/2)*L butterflies through the frame RAM; inputs are stalled meanwhile. Reset leaves the frame RAM as is.
`default_nettype none
`include "radix2_complex_fft_macros.svh"
module radix2_complex_fft (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic                                  cfg_index_i,
  input  logic [rfft_pkg::CfgLogW-1:0]          cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  operation_i,
  input  logic signed [rfft_pkg::SampleBits-1:0] sample_re_i,
  input  logic signed [rfft_pkg::SampleBits-1:0] sample_im_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  valid_res_o,
  output logic signed [rfft_pkg::DataBits-1:0]  bin_re_o,
  output logic signed [rfft_pkg::DataBits-1:0]  bin_im_o,
  output logic [rfft_pkg::MaxLog2-1:0]          bin_index_o,
  output logic                                  last_bin_o
);

  localparam int AW = rfft_pkg::MaxLog2;
  localparam int CW = rfft_pkg::CountW;
  localparam int SW = rfft_pkg::StageW;
  localparam int RW = rfft_pkg::RomIdxW;
  localparam int TB = rfft_pkg::TwBits;
  localparam int PadW = rfft_pkg::DataBits - rfft_pkg::SampleBits;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_WAIT,
    ST_BR_CHK, ST_BR_RDI, ST_BR_RDJ, ST_BR_WRI, ST_BR_WRJ,
    ST_BF_RDJ, ST_BF_RDI, ST_BF_TW, ST_BF_WRJ, ST_BF_WRI
  } state_e;

  state_e state_q;

  // configuration registers
  logic [rfft_pkg::CfgLogW-1:0] points_log2_q;
  logic                         neg_exp_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_log2_q <= rfft_pkg::CfgLogW'(rfft_pkg::MaxLog2);
      neg_exp_q     <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        rfft_pkg::CfgPointsLog2: points_log2_q <= cfg_data_i;
        rfft_pkg::CfgNegExp:     neg_exp_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // active length, clamped to the supported range
  logic [SW-1:0] l_act;
  logic [CW-1:0] n_pts;
  logic [AW-1:0] n_m1;
  logic [RW-1:0] half_m1;

  always_comb begin
    l_act = points_log2_q;
    if (points_log2_q == '0) l_act = SW'(1);
    if (points_log2_q > SW'(rfft_pkg::MaxLog2)) l_act = SW'(rfft_pkg::MaxLog2);
  end

  assign n_pts   = CW'(1) << l_act;
  assign n_m1    = AW'(n_pts - CW'(1));
  assign half_m1 = RW'((n_pts >> 1) - CW'(1));

  // control registers
  logic [CW-1:0] load_count_q, read_count_q;
  logic          results_ready_q;
  logic [AW-1:0] i_q;
  logic [RW-1:0] p_q;
  logic [SW-1:0] s_q;
  rfft_pkg::cword_t a_q;
  logic signed [TB:0] w_re_q, w_im_q;
  logic [AW-1:0] rd_index_q;
  logic          rd_last_q;

  logic          out_valid_q, valid_res_q, last_bin_q;
  logic signed [rfft_pkg::DataBits-1:0] bin_re_q, bin_im_q;
  logic [AW-1:0] bin_index_q;

  logic out_free;
  logic in_acc;
  logic out_set;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || ((operation_i == rfft_pkg::OpRead) && !out_free);
  assign in_acc     = in_valid_i && !in_stall_o;

  // output register loaded this cycle
  assign out_set = ((state_q == ST_IDLE) && in_acc && (operation_i == rfft_pkg::OpRead) &&
                    !results_ready_q) || ((state_q == ST_RD_WAIT) && out_free);

  // load and read addressing
  logic [AW-1:0] load_idx;
  logic [CW-1:0] load_next;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] rd_next;

  assign load_idx  = results_ready_q ? '0 : load_count_q[AW-1:0];
  assign load_next = (results_ready_q ? CW'(0) : load_count_q) + CW'(1);
  assign rd_idx    = (read_count_q >= n_pts) ? CW'(0) : read_count_q;
  assign rd_next   = ((rd_idx + CW'(1)) >= n_pts) ? CW'(0) : rd_idx + CW'(1);

  // bit-reversed partner of i over l bits
  logic [AW-1:0] rev_full, j_rev;
  always_comb begin
    for (int b = 0; b < AW; b++) begin
      rev_full[b] = i_q[AW-1-b];
    end
  end
  assign j_rev = rev_full >> (SW'(AW) - l_act);

  // butterfly addressing: pair index p within stage s
  logic [AW-1:0] p_ext, m_part, bi, bj;
  logic [RW-1:0] tw_k;
  assign p_ext  = AW'(p_q);
  assign m_part = p_ext & ((AW'(1) << s_q) - AW'(1));
  assign bi     = ((p_ext >> s_q) << (s_q + SW'(1))) | m_part;
  assign bj     = bi | (AW'(1) << s_q);
  assign tw_k   = RW'(m_part << (SW'(RW) - s_q));

  // frame RAM
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  rfft_pkg::cword_t ram_wdata, ram_rdata;
  rfft_pkg::cword_t y_i, y_j;
  rfft_pkg::cword_t sample_w;
  rfft_pkg::bfly_ctrl_t bf_ctrl;

  assign sample_w.re = {{PadW{sample_re_i[rfft_pkg::SampleBits-1]}}, sample_re_i};
  assign sample_w.im = {{PadW{sample_im_i[rfft_pkg::SampleBits-1]}}, sample_im_i};

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = '0;
    ram_raddr = '0;
    ram_wdata = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && operation_i == rfft_pkg::OpLoad) begin
          ram_we    = 1'b1;
          ram_waddr = load_idx;
          ram_wdata = sample_w;
        end
        if (in_acc && operation_i == rfft_pkg::OpRead && results_ready_q) begin
          ram_re    = 1'b1;
          ram_raddr = rd_idx[AW-1:0];
        end
      end
      ST_BR_RDI: begin
        ram_re    = 1'b1;
        ram_raddr = i_q;
      end
      ST_BR_RDJ: begin
        ram_re    = 1'b1;
        ram_raddr = j_rev;
      end
      ST_BR_WRI: begin
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = ram_rdata;
      end
      ST_BR_WRJ: begin
        ram_we    = 1'b1;
        ram_waddr = j_rev;
        ram_wdata = a_q;
      end
      ST_BF_RDJ: begin
        ram_re    = 1'b1;
        ram_raddr = bj;
      end
      ST_BF_RDI: begin
        ram_re    = 1'b1;
        ram_raddr = bi;
      end
      ST_BF_WRJ: begin
        ram_we    = 1'b1;
        ram_waddr = bj;
        ram_wdata = y_j;
      end
      ST_BF_WRI: begin
        ram_we    = 1'b1;
        ram_waddr = bi;
        ram_wdata = y_i;
      end
      default: ;
    endcase
  end

  assign bf_ctrl.mul_en = (state_q == ST_BF_RDI);
  assign bf_ctrl.t_en   = (state_q == ST_BF_TW);

  rfft_ram #(
    .AddrW (AW),
    .Width ($bits(rfft_pkg::cword_t))
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rfft_bfly u_bfly (
    .clk_i  (clk_i),
    .ctrl_i (bf_ctrl),
    .xj_i   (ram_rdata),
    .xi_i   (ram_rdata),
    .w_re_i (w_re_q),
    .w_im_i (w_im_q),
    .yi_o   (y_i),
    .yj_o   (y_j)
  );

  // sequencer, counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      load_count_q    <= '0;
      read_count_q    <= '0;
      results_ready_q <= 1'b0;
      i_q             <= '0;
      p_q             <= '0;
      s_q             <= '0;
      a_q             <= '0;
      w_re_q          <= '0;
      w_im_q          <= '0;
      rd_index_q      <= '0;
      rd_last_q       <= 1'b0;
      out_valid_q     <= 1'b0;
      valid_res_q     <= 1'b0;
      bin_re_q        <= '0;
      bin_im_q        <= '0;
      bin_index_q     <= '0;
      last_bin_q      <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && !out_set) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && operation_i == rfft_pkg::OpLoad) begin
            results_ready_q <= 1'b0;
            read_count_q    <= '0;
            if (load_next >= n_pts) begin
              load_count_q <= '0;
              i_q          <= '0;
              state_q      <= ST_BR_CHK;
            end else begin
              load_count_q <= load_next;
            end
          end else if (in_acc) begin
            if (results_ready_q) begin
              rd_index_q   <= rd_idx[AW-1:0];
              rd_last_q    <= (rd_idx[AW-1:0] == n_m1);
              read_count_q <= rd_next;
              state_q      <= ST_RD_WAIT;
            end else begin
              out_valid_q <= 1'b1;
              valid_res_q <= 1'b0;
              bin_re_q    <= '0;
              bin_im_q    <= '0;
              bin_index_q <= '0;
              last_bin_q  <= 1'b0;
            end
          end
        end
        ST_RD_WAIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            valid_res_q <= 1'b1;
            bin_re_q    <= ram_rdata.re;
            bin_im_q    <= ram_rdata.im;
            bin_index_q <= rd_index_q;
            last_bin_q  <= rd_last_q;
            state_q     <= ST_IDLE;
          end
        end
        ST_BR_CHK: begin
          if (j_rev > i_q) begin
            state_q <= ST_BR_RDI;
          end else if (i_q == n_m1) begin
            p_q     <= '0;
            s_q     <= '0;
            state_q <= ST_BF_RDJ;
          end else begin
            i_q <= i_q + AW'(1);
          end
        end
        ST_BR_RDI: state_q <= ST_BR_RDJ;
        ST_BR_RDJ: begin
          a_q     <= ram_rdata;
          state_q <= ST_BR_WRI;
        end
        ST_BR_WRI: state_q <= ST_BR_WRJ;
        ST_BR_WRJ: begin
          if (i_q == n_m1) begin
            p_q     <= '0;
            s_q     <= '0;
            state_q <= ST_BF_RDJ;
          end else begin
            i_q     <= i_q + AW'(1);
            state_q <= ST_BR_CHK;
          end
        end
        ST_BF_RDJ: begin
          w_re_q  <= (TB+1)'(rfft_pkg::CosRom[tw_k]);
          w_im_q  <= neg_exp_q ? -(TB+1)'(rfft_pkg::SinRom[tw_k])
                               : (TB+1)'(rfft_pkg::SinRom[tw_k]);
          state_q <= ST_BF_RDI;
        end
        ST_BF_RDI: state_q <= ST_BF_TW;
        ST_BF_TW:  state_q <= ST_BF_WRJ;
        ST_BF_WRJ: state_q <= ST_BF_WRI;
        ST_BF_WRI: begin
          if (p_q != half_m1) begin
            p_q     <= p_q + RW'(1);
            state_q <= ST_BF_RDJ;
          end else if (s_q != l_act - SW'(1)) begin
            p_q     <= '0;
            s_q     <= s_q + SW'(1);
            state_q <= ST_BF_RDJ;
          end else begin
            results_ready_q <= 1'b1;
            load_count_q    <= '0;
            read_count_q    <= '0;
            state_q         <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign valid_res_o = valid_res_q;
  assign bin_re_o    = bin_re_q;
  assign bin_im_o    = bin_im_q;
  assign bin_index_o = bin_index_q;
  assign last_bin_o  = last_bin_q;

  // checks on the sequencer
  `RFFT_ASSERT_NEVER(a_load_count_range, clk_i, rst_ni, load_count_q[CW-1])
  `RFFT_ASSERT(a_ready_after_bfly, clk_i, rst_ni, $rose(results_ready_q) |-> ($past(state_q) == ST_BF_WRI))
  `RFFT_ASSERT(a_tw_after_mul, clk_i, rst_ni, (state_q == ST_BF_TW) |-> ($past(state_q) == ST_BF_RDI))
  `RFFT_ASSERT(a_bin_from_ram, clk_i, rst_ni, ($rose(out_valid_q) && valid_res_q) |-> ($past(state_q) == ST_RD_WAIT))

endmodule
`default_nettype wire

// ----- sim/radix2_complex_fft_checker.sv -----
// Checker for the radix-2 FFT: watches the channels, predicts the bins and compares them.
module radix2_complex_fft_checker
  import rfft_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic                       cfg_index_i,
  input  logic [CfgLogW-1:0]         cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic                       operation_i,
  input  logic signed [SampleBits-1:0] sample_re_i,
  input  logic signed [SampleBits-1:0] sample_im_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic                       valid_res_i,
  input  logic signed [DataBits-1:0] bin_re_i,
  input  logic signed [DataBits-1:0] bin_im_i,
  input  logic [MaxLog2-1:0]         bin_index_i,
  input  logic                       last_bin_i,
  output int                         errors_o,
  output int                         pending_o
);

  typedef struct packed {
    logic                       valid;
    logic signed [DataBits-1:0] re;
    logic signed [DataBits-1:0] im;
    logic [MaxLog2-1:0]         idx;
    logic                       last;
  } bin_t;

  localparam real PiVal = 3.14159265358979323846;

  // twiddle tables, rounded half away from zero, +1.0 saturated
  int cos_tab [RomSize];
  int sin_tab [RomSize];

  // predicted block state
  logic signed [DataBits-1:0] frame_re [MaxPoints];
  logic signed [DataBits-1:0] frame_im [MaxPoints];
  int   loaded, bin_ptr, len_log2, neg_exp, err_count;
  bit   bins_ready;
  bin_t expected_bins [$];

  function automatic int round_tw(input real v);
    real mag;
    int  r;
    mag = (v < 0.0) ? -v : v;
    r   = $rtoi(mag * 32768.0 + 0.5);
    if (r > 32767) r = 32767;
    return (v < 0.0) ? -r : r;
  endfunction

  initial begin
    for (int k = 0; k < RomSize; k++) begin
      cos_tab[k] = round_tw($cos(2.0 * PiVal * k / MaxPoints));
      sin_tab[k] = round_tw($sin(2.0 * PiVal * k / MaxPoints));
    end
  end

  function automatic int eff_log2();
    if (len_log2 < 1) return 1;
    if (len_log2 > MaxLog2) return MaxLog2;
    return len_log2;
  endfunction

  // in-place DIT transform of the first 2^l entries
  task automatic fft_in_place(input int l);
    int     n, j, half, k;
    longint wr, wi, xr, xi, tr, ti, ar, ai;
    logic signed [DataBits-1:0] sw;
    n = 1 << l;
    for (int i = 0; i < n; i++) begin
      j = 0;
      for (int b = 0; b < l; b++) j |= ((i >> b) & 1) << (l - 1 - b);
      if (j > i) begin
        sw = frame_re[i]; frame_re[i] = frame_re[j]; frame_re[j] = sw;
        sw = frame_im[i]; frame_im[i] = frame_im[j]; frame_im[j] = sw;
      end
    end
    for (int s = 0; s < l; s++) begin
      half = 1 << s;
      for (int m = 0; m < half; m++) begin
        k  = m << (MaxLog2 - s - 1);
        wr = cos_tab[k];
        wi = neg_exp ? -sin_tab[k] : sin_tab[k];
        for (int i = m; i < n; i += 2 * half) begin
          j  = i + half;
          xr = frame_re[j];
          xi = frame_im[j];
          tr = (wr * xr - wi * xi + 64'sd16384) >>> TwFrac;
          ti = (wr * xi + wi * xr + 64'sd16384) >>> TwFrac;
          ar = frame_re[i];
          ai = frame_im[i];
          frame_re[j] = DataBits'(ar - tr);
          frame_im[j] = DataBits'(ai - ti);
          frame_re[i] = DataBits'(ar + tr);
          frame_im[i] = DataBits'(ai + ti);
        end
      end
    end
  endtask

  // one accepted input transfer
  task automatic take_item();
    int   l, n, idx;
    bin_t b;
    l = eff_log2();
    n = 1 << l;
    if (operation_i == OpLoad) begin
      if (bins_ready) begin
        bins_ready = 0; loaded = 0; bin_ptr = 0;
      end
      idx = loaded % MaxPoints;
      frame_re[idx] = {{(DataBits-SampleBits){sample_re_i[SampleBits-1]}}, sample_re_i};
      frame_im[idx] = {{(DataBits-SampleBits){sample_im_i[SampleBits-1]}}, sample_im_i};
      loaded = (loaded + 1) & 11'h7ff;
      if (loaded >= n) begin
        fft_in_place(l);
        bins_ready = 1; loaded = 0; bin_ptr = 0;
      end
    end else begin
      b = '0;
      if (bins_ready) begin
        if (bin_ptr >= n) bin_ptr = 0;
        b.valid = 1'b1;
        b.re    = frame_re[bin_ptr];
        b.im    = frame_im[bin_ptr];
        b.idx   = MaxLog2'(bin_ptr);
        b.last  = (bin_ptr == n - 1);
        bin_ptr = (bin_ptr + 1 >= n) ? 0 : bin_ptr + 1;
      end
      expected_bins.push_back(b);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bin_t want, got;
    if (!rst_ni) begin
      loaded = 0; bin_ptr = 0; bins_ready = 0;
      len_log2 = MaxLog2; neg_exp = 0; err_count = 0;
      expected_bins.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      // result transfer against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        got = '{valid_res_i, bin_re_i, bin_im_i, bin_index_i, last_bin_i};
        if (expected_bins.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result valid=%0b re=%0d im=%0d idx=%0d last=%0b",
                   $time, got.valid, got.re, got.im, got.idx, got.last);
        end else begin
          want = expected_bins.pop_front();
          if (got !== want) begin
            err_count++;
            $display("%0t: bin mismatch exp valid=%0b re=%0d im=%0d idx=%0d last=%0b",
                     $time, want.valid, want.re, want.im, want.idx, want.last);
            $display("%0t:              got valid=%0b re=%0d im=%0d idx=%0d last=%0b",
                     $time, got.valid, got.re, got.im, got.idx, got.last);
          end
        end
      end
      // register write
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgPointsLog2) len_log2 = cfg_data_i;
        else if (cfg_index_i == CfgNegExp) neg_exp = cfg_data_i[0];
      end
      if (in_valid_i && !in_stall_i) take_item();
      errors_o  <= err_count;
      pending_o <= expected_bins.size();
    end
  end

endmodule

// ----- sim/tb_radix2_complex_fft.sv -----
// Testbench top for the radix-2 FFT: stimulus, idling and verdict.
module tb_radix2_complex_fft;
  import rfft_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0, cfg_ready_o, cfg_index_i = 1'b0;
  logic [CfgLogW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0, in_stall_o, operation_i = OpLoad;
  logic signed [SampleBits-1:0] sample_re_i = '0, sample_im_i = '0;
  logic out_valid_o, out_stall_i = 1'b0, valid_res_o, last_bin_o;
  logic signed [DataBits-1:0] bin_re_o, bin_im_o;
  logic [MaxLog2-1:0] bin_index_o;
  int errors, pending;

  // own view of frame progress, to shape sequences and keep reads on written entries
  int  cur_log2 = MaxLog2, fill = 0, rd_pos = 0, written = 0, settle_cycles = 20;
  bit  have_bins = 0, quiet = 0;
  int  n_loads = 0, n_reads = 0, n_frames = 0, n_cfg = 0;
  int  stall_left = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  radix2_complex_fft i_dut (.*);

  radix2_complex_fft_checker i_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .operation_i, .sample_re_i, .sample_im_i,
    .out_valid_i(out_valid_o), .out_stall_i, .valid_res_i(valid_res_o), .bin_re_i(bin_re_o),
    .bin_im_i(bin_im_o), .bin_index_i(bin_index_o), .last_bin_i(last_bin_o),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    #100000000;
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end

  // random gap length: mostly none, some short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (stall_left > 0) stall_left <= stall_left - 1;
    else if (quiet) out_stall_i <= 1'b0;
    else begin
      out_stall_i <= ($urandom_range(0, 99) < 30);
      stall_left  <= ($urandom_range(0, 99) < 5) ? $urandom_range(10, 40) : gap_len();
    end
  end

  function automatic int eff_log2();
    if (cur_log2 < 1) return 1;
    if (cur_log2 > MaxLog2) return MaxLog2;
    return cur_log2;
  endfunction

  function automatic logic signed [SampleBits-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return '0;
      3: return '1;
      default: return SampleBits'($urandom);
    endcase
  endfunction

  // a read is safe unless it would return a frame entry never written
  function automatic bit read_safe();
    int n;
    n = 1 << eff_log2();
    return !have_bins || (((rd_pos >= n) ? 0 : rd_pos) < written);
  endfunction

  // one input transfer, with the frame view updated
  task automatic send(input logic op, input logic signed [SampleBits-1:0] re,
                      input logic signed [SampleBits-1:0] im);
    int g, l, n;
    g = gap_len();
    if (g > 0) begin
      in_valid_i = 1'b0;
      repeat (g) @(negedge clk_i);
    end
    operation_i = op;
    sample_re_i = re;
    sample_im_i = im;
    in_valid_i  = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    l = eff_log2();
    n = 1 << l;
    settle_cycles = 20;
    if (op == OpLoad) begin
      n_loads++;
      if (have_bins) begin
        have_bins = 0; fill = 0; rd_pos = 0;
      end
      fill = fill + 1;
      if (fill > written) written = fill;
      if (fill >= n) begin
        have_bins = 1; fill = 0; rd_pos = 0; n_frames++;
        settle_cycles = 5 * n + 5 * (n / 2) * l + 50;
      end
    end else begin
      n_reads++;
      if (have_bins) begin
        if (rd_pos >= n) rd_pos = 0;
        rd_pos = (rd_pos + 1 >= n) ? 0 : rd_pos + 1;
      end
    end
  endtask

  task automatic load_one();
    send(OpLoad, pick_sample(), pick_sample());
  endtask

  task automatic read_one();
    if (read_safe()) send(OpRead, pick_sample(), pick_sample());
    else load_one();
  endtask

  // drain outstanding bins and let any transform finish
  task automatic settle();
    in_valid_i = 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (settle_cycles) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic idx, input logic [CfgLogW-1:0] val);
    @(negedge clk_i);
    cfg_index_i = idx;
    cfg_data_i  = val;
    cfg_valid_i = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    if (idx == CfgPointsLog2) cur_log2 = val;
    n_cfg++;
  endtask

  // random phase: mostly whole frames then reads, some noise
  task automatic run_phase(input int l, input int neg, input int items);
    int done, n, cnt;
    settle();
    cfg_write(CfgPointsLog2, CfgLogW'(l));
    cfg_write(CfgNegExp, CfgLogW'(neg));
    n = 1 << eff_log2();
    done = 0;
    while (done < items) begin
      quiet = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 99) < 80) begin
        for (int i = fill; i < n; i++) load_one();
        cnt = $urandom_range(1, (n > 32) ? 32 : n + 2);
        for (int i = 0; i < cnt; i++) read_one();
        done += n + cnt;
      end else begin
        cnt = $urandom_range(1, 6);
        for (int i = 0; i < cnt; i++)
          if ($urandom_range(0, 1)) load_one(); else read_one();
        done += cnt;
      end
    end
    quiet = 0;
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: early read, extremes at four points, wrap past the last bin
    cfg_write(CfgPointsLog2, CfgLogW'(2));
    cfg_write(CfgNegExp, CfgLogW'(0));
    send(OpRead, '0, '0);
    send(OpLoad, 16'sh7fff, 16'sh8000);
    send(OpLoad, 16'sh8000, 16'sh7fff);
    send(OpLoad, 16'sh0000, 16'shffff);
    send(OpLoad, 16'shffff, 16'sh5555);
    repeat (6) send(OpRead, '0, '0);
    // a load after the transform starts a new frame; then shorten it mid-frame
    send(OpLoad, 16'sh7fff, 16'sh7fff);
    send(OpLoad, 16'sh8000, 16'sh8000);
    send(OpLoad, 16'sh2aaa, 16'shd555);
    settle();
    cfg_write(CfgPointsLog2, CfgLogW'(1));
    cfg_write(CfgNegExp, CfgLogW'(1));
    send(OpLoad, 16'sh1234, 16'shedcb);
    repeat (3) send(OpRead, '0, '0);
    // lengthen after the transform: reads go on from the stored bin position
    settle();
    cfg_write(CfgPointsLog2, CfgLogW'(2));
    repeat (3) send(OpRead, '0, '0);

    // random part: short lengths, out-of-range codes, one full-length frame
    run_phase(0, 1, 16);
    run_phase(1, 0, 16);
    run_phase(2, 1, 20);
    run_phase(3, 0, 24);
    run_phase(4, 1, 32);
    run_phase(15, 1, 1000);
    run_phase(3, 1, 24);

    settle();
    repeat (20) @(negedge clk_i);
    $display("Covered %0d loads, %0d reads, %0d transformed frames, %0d register writes,",
             n_loads, n_reads, n_frames, n_cfg);
    $display("lengths 2 to 16 and 1024 with both twiddle signs and out-of-range length codes.");
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/rfft_pkg.sv
hw/rtl/rfft_ram.sv
hw/rtl/rfft_bfly.sv
hw/rtl/radix2_complex_fft.sv
sim/radix2_complex_fft_checker.sv
sim/tb_radix2_complex_fft.sv
